>>> hw/rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the signed integer ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

  // Default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } action_t;

  // Per-item control that travels down the pipeline beside the data
  typedef struct packed {
    action_t action;
    logic    neg;   // negate quotient at the end
    logic    dz;    // divide by zero seen
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/signed_integer_alu.sv
// ----------------------------------------------------------------------------
// signed_integer_alu
// Pipelined signed add, subtract, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
//
//  stream  | dir | tdata (low bit up)             | tuser
//  --------+-----+--------------------------------+--------------------
//  s_axis  | in  | operand_a, operand_b, zero pad | action
//  m_axis  | out | result, zero pad               | divide_by_zero
//
//  DATA_WIDTH + 2 register stages: one entry stage, one stage per operand
//  bit for the shift-add / shift-subtract steps, one output stage. A result
//  is registered in the output stage after the entry stage and every bit stage.
//  A new transaction is taken every cycle while results drain.
//  Reset clears every stage valid bit; data registers are not reset.
//  While a result waits in the output register the whole pipeline holds.
//
`default_nettype none

module signed_integer_alu #(
  parameter int unsigned DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // operand_a, operand_b
  input  wire logic [8*((2*DATA_WIDTH+7)/8)-1:0]     s_axis_tdata,
  // action
  input  wire logic [1:0]                            s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // result
  output logic [8*((DATA_WIDTH+7)/8)-1:0]            m_axis_tdata,
  // divide_by_zero
  output logic                                        m_axis_tuser
);

  localparam int unsigned OutW = 8 * ((DATA_WIDTH + 7) / 8);

  logic                  ce;
  logic                  stg_valid [0:DATA_WIDTH];
  sia_pkg::ctl_t         stg_ctl   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] stg_acc   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] stg_x     [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] stg_q     [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] result;
  logic                  dz;

  // Pipeline advances unless a result is held at the output
  assign ce            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = ce;

  // Entry stage
  sia_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_axis_tvalid),
    .in_action (sia_pkg::action_t'(s_axis_tuser)),
    .in_a      (s_axis_tdata[DATA_WIDTH-1:0]),
    .in_b      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid (stg_valid[0]),
    .out_ctl   (stg_ctl[0]),
    .out_acc   (stg_acc[0]),
    .out_x     (stg_x[0]),
    .out_q     (stg_q[0])
  );

  // One stage per operand bit
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    sia_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (stg_valid[i]),
      .in_ctl    (stg_ctl[i]),
      .in_acc    (stg_acc[i]),
      .in_x      (stg_x[i]),
      .in_q      (stg_q[i]),
      .out_valid (stg_valid[i+1]),
      .out_ctl   (stg_ctl[i+1]),
      .out_acc   (stg_acc[i+1]),
      .out_x     (stg_x[i+1]),
      .out_q     (stg_q[i+1])
    );
  end

  // Output stage
  sia_finish #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_finish (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (stg_valid[DATA_WIDTH]),
    .in_ctl     (stg_ctl[DATA_WIDTH]),
    .in_acc     (stg_acc[DATA_WIDTH]),
    .in_x       (stg_x[DATA_WIDTH]),
    .in_q       (stg_q[DATA_WIDTH]),
    .out_valid  (m_axis_tvalid),
    .out_result (result),
    .out_dz     (dz)
  );

  assign m_axis_tdata = OutW'(result);
  assign m_axis_tuser = dz;

  // A zero divisor always yields a zero result
  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> result == '0)
    else $error("divide by zero result not zero");

  // The zero-divisor flag only rides with divide transactions
  a_dz_div_only : assert property (@(posedge clk) disable iff (rst)
    stg_valid[DATA_WIDTH] && stg_ctl[DATA_WIDTH].dz
      |-> stg_ctl[DATA_WIDTH].action == sia_pkg::OP_DIV)
    else $error("zero-divisor flag on non-divide");

  // A finished last bit stage reaches the output on the next advance
  a_last_to_out : assert property (@(posedge clk) disable iff (rst)
    ce && stg_valid[DATA_WIDTH] |=> m_axis_tvalid)
    else $error("transaction lost at output stage");

endmodule

`default_nettype wire

>>> hw/rtl/sia_prep.sv
// ----------------------------------------------------------------------------
// sia_prep
// Entry stage: unpacks operands, takes magnitudes for divide, flags zero
// divisor and loads the working registers for the bit stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_prep #(
  parameter int unsigned DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_valid,
  input  wire sia_pkg::action_t      in_action,
  input  wire logic [DATA_WIDTH-1:0] in_a,
  input  wire logic [DATA_WIDTH-1:0] in_b,
  output logic                       out_valid,
  output sia_pkg::ctl_t              out_ctl,
  output logic [DATA_WIDTH-1:0]      out_acc,
  output logic [DATA_WIDTH-1:0]      out_x,
  output logic [DATA_WIDTH-1:0]      out_q
);

  logic                  sign_a;
  logic                  sign_b;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  sia_pkg::ctl_t         ctl_next;
  logic [DATA_WIDTH-1:0] acc_next;
  logic [DATA_WIDTH-1:0] x_next;
  logic [DATA_WIDTH-1:0] q_next;

  assign sign_a = in_a[DATA_WIDTH-1];
  assign sign_b = in_b[DATA_WIDTH-1];
  assign mag_a  = sign_a ? (~in_a + 1'b1) : in_a;
  assign mag_b  = sign_b ? (~in_b + 1'b1) : in_b;

  // Load working registers per operation
  always_comb begin
    ctl_next.action = in_action;
    ctl_next.neg    = 1'b0;
    ctl_next.dz     = 1'b0;
    acc_next        = in_a;
    x_next          = in_b;
    q_next          = in_a;
    case (in_action)
      sia_pkg::OP_MUL: begin
        acc_next = '0;
      end
      sia_pkg::OP_DIV: begin
        ctl_next.neg = sign_a ^ sign_b;
        ctl_next.dz  = (in_b == '0);
        acc_next     = '0;
        x_next       = mag_b;
        q_next       = mag_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_ctl <= ctl_next;
      out_acc <= acc_next;
      out_x   <= x_next;
      out_q   <= q_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sia_step.sv
// ----------------------------------------------------------------------------
// sia_step
// One radix-2 bit stage: a shift-and-add step for multiply or a restoring
// shift-and-subtract step for divide. Add and subtract pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_step #(
  parameter int unsigned DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_valid,
  input  wire sia_pkg::ctl_t         in_ctl,
  input  wire logic [DATA_WIDTH-1:0] in_acc,
  input  wire logic [DATA_WIDTH-1:0] in_x,
  input  wire logic [DATA_WIDTH-1:0] in_q,
  output logic                       out_valid,
  output sia_pkg::ctl_t              out_ctl,
  output logic [DATA_WIDTH-1:0]      out_acc,
  output logic [DATA_WIDTH-1:0]      out_x,
  output logic [DATA_WIDTH-1:0]      out_q
);

  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH-1:0] diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] acc_next;
  logic [DATA_WIDTH-1:0] x_next;
  logic [DATA_WIDTH-1:0] q_next;

  // Divide: shift next dividend bit into remainder, subtract if it fits
  assign rem_sh = {in_acc[DATA_WIDTH-2:0], in_q[DATA_WIDTH-1]};
  assign diff   = rem_sh - in_x;
  assign take   = in_acc[DATA_WIDTH-1] || (rem_sh >= in_x);

  always_comb begin
    acc_next = in_acc;
    x_next   = in_x;
    q_next   = in_q;
    case (in_ctl.action)
      sia_pkg::OP_MUL: begin
        // q holds remaining multiplier bits, x the shifted multiplicand
        acc_next = in_q[0] ? (in_acc + in_x) : in_acc;
        x_next   = in_x << 1;
        q_next   = in_q >> 1;
      end
      sia_pkg::OP_DIV: begin
        acc_next = take ? diff : rem_sh;
        q_next   = {in_q[DATA_WIDTH-2:0], take};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_ctl <= in_ctl;
      out_acc <= acc_next;
      out_x   <= x_next;
      out_q   <= q_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sia_finish.sv
// ----------------------------------------------------------------------------
// sia_finish
// Output stage: add or subtract, pick the product, or sign-fix the quotient
// (zero on a zero divisor); holds the result register of the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_finish #(
  parameter int unsigned DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_valid,
  input  wire sia_pkg::ctl_t         in_ctl,
  input  wire logic [DATA_WIDTH-1:0] in_acc,
  input  wire logic [DATA_WIDTH-1:0] in_x,
  input  wire logic [DATA_WIDTH-1:0] in_q,
  output logic                       out_valid,
  output logic [DATA_WIDTH-1:0]      out_result,
  output logic                       out_dz
);

  logic [DATA_WIDTH-1:0] result_next;

  always_comb begin
    case (in_ctl.action)
      sia_pkg::OP_ADD: result_next = in_acc + in_x;
      sia_pkg::OP_SUB: result_next = in_acc - in_x;
      sia_pkg::OP_MUL: result_next = in_acc;
      default: begin
        if (in_ctl.dz) begin
          result_next = '0;
        end else if (in_ctl.neg) begin
          result_next = ~in_q + 1'b1;
        end else begin
          result_next = in_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_result <= result_next;
      out_dz     <= in_ctl.dz;
    end
  end

endmodule

`default_nettype wire
